/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/rpdbb_pkg.sv */
// Shared widths, codes and types of the rest temperature controller.
package rpdbb_pkg;

    localparam int TARGET_W   = 17;
    localparam int REST_W     = 8;
    localparam int KIND_W     = 2;
    localparam int TEMP_W     = 18;
    localparam int TIME_W     = 32;
    localparam int MIN_W      = 8;
    localparam int ERR_W      = 19;
    localparam int FE_W       = 32;
    localparam int THR_W      = 34;
    localparam int LHS_W      = 51;
    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [TARGET_W-1:0] TARGET_RST = 17'd65000;
    localparam logic [REST_W-1:0]   REST_RST   = 8'd0;

    // register select is paddr[2]
    localparam logic REG_TARGET = 1'b0;
    localparam logic REG_REST   = 1'b1;

    // result tdata bit positions
    localparam int OB_HEATER  = 0;
    localparam int OB_PHASE   = 1;
    localparam int OB_BUZZER  = 3;
    localparam int OB_MIN     = 4;
    localparam int OB_REACHED = 12;

    typedef enum logic [1:0] {
        PH_HEAT = 2'd0,
        PH_HOLD = 2'd1,
        PH_DONE = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_CONT   = 2'd1,
        KIND_START  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        HACT_KEEP = 2'd0,
        HACT_REG  = 2'd1,
        HACT_OFF  = 2'd2
    } t_hact;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [REST_W-1:0]   rest;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TEMP_W-1:0] temp;
        logic [TIME_W-1:0] now;
    } t_item;

    typedef struct packed {
        t_hact              act;
        t_phase             phase;
        logic               buzzer;
        logic [MIN_W-1:0]   minutes;
        logic               reached;
        logic [ERR_W-1:0]   err;
        logic [FE_W-1:0]    fe;
    } t_s1;

endpackage

/* hw/rtl/rpdbb_cfg.sv */
// APB register file and registered heater threshold.
module rpdbb_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rpdbb_pkg::APB_AW-1:0]        paddr,
    input  logic [rpdbb_pkg::APB_DW-1:0]        pwdata,
    output logic [rpdbb_pkg::APB_DW-1:0]        prdata,
    output logic                                pready,
    output rpdbb_pkg::t_cfg                     o_cfg,
    output logic signed [rpdbb_pkg::THR_W-1:0]  o_thr
);

    localparam int TW = rpdbb_pkg::THR_W;
    localparam int GW = rpdbb_pkg::TARGET_W;
    localparam int RW = rpdbb_pkg::REST_W;
    localparam int DW = rpdbb_pkg::APB_DW;

    // 4 * (833360000 - 6667 * target), the threshold scaled to match u * 15625
    localparam logic signed [TW-1:0] THR_BASE  = 34'sd3333440000;
    localparam logic signed [TW-1:0] THR_SLOPE = 34'sd26668;

    logic [GW-1:0]          r_target;
    logic [RW-1:0]          r_rest;
    logic signed [TW-1:0]   r_thr;
    logic signed [TW-1:0]   n_thr;
    logic                   w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= rpdbb_pkg::TARGET_RST;
            r_rest   <= rpdbb_pkg::REST_RST;
        end else if (w_wr) begin
            unique case (paddr[2])
                rpdbb_pkg::REG_TARGET: r_target <= pwdata[GW-1:0];
                rpdbb_pkg::REG_REST:   r_rest   <= pwdata[RW-1:0];
                default: ;
            endcase
        end
    end

    assign n_thr = THR_BASE - THR_SLOPE * $signed({{(TW-GW){1'b0}}, r_target});

    always_ff @(posedge i_clk) begin
        r_thr <= n_thr;
    end

    always_comb begin
        unique case (paddr[2])
            rpdbb_pkg::REG_TARGET: prdata = {{(DW-GW){1'b0}}, r_target};
            rpdbb_pkg::REG_REST:   prdata = {{(DW-RW){1'b0}}, r_rest};
            default:               prdata = '0;
        endcase
    end

    assign o_cfg.target = r_target;
    assign o_cfg.rest   = r_rest;
    assign o_thr        = r_thr;

endmodule

/* hw/rtl/rpdbb_ctrl.sv */
// Phase sequencer, error filter and hold timer; registers the first stage.
module rpdbb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  rpdbb_pkg::t_item    i_item,
    input  rpdbb_pkg::t_cfg     i_cfg,
    input  logic                i_ready,
    output logic                o_ready,
    output logic                o_valid,
    output rpdbb_pkg::t_s1      o_s1
);

    localparam int EW = rpdbb_pkg::ERR_W;
    localparam int FW = rpdbb_pkg::FE_W;
    localparam int GW = rpdbb_pkg::TARGET_W;
    localparam int XW = rpdbb_pkg::TEMP_W;
    localparam int MW = rpdbb_pkg::MIN_W;
    localparam int NW = FW + 1;         // 1024*e + eF
    localparam int VW = NW + 2;         // biased numerator
    localparam int HW = VW - 16;        // upper part of biased numerator
    localparam int WW = HW + 1;         // folded remainder sum
    localparam int PW = WW + 21;        // reciprocal product

    // bias of 5 * 2^32 makes the numerator positive; floor division then is plain
    localparam logic [VW-1:0] DIV_BIAS = 35'h5_0000_0000;
    localparam int            DIV_K16  = 13107;     // (2^16 - 1) / 5
    localparam int            RECIP5   = 1677722;   // ceil(2^23 / 5)
    localparam int            MIN_SAT_S = 15360;    // 256 minutes in seconds
    localparam int            RECIP15  = 4370;      // ceil(2^16 / 15)

    rpdbb_pkg::t_phase          r_phase, n_phase;
    logic [FW-1:0]              r_fe, n_fe;
    logic [rpdbb_pkg::TIME_W-1:0] r_hold, n_hold;
    logic                       r_v;
    rpdbb_pkg::t_s1             r_s1, n_s1;
    logic                       w_fire;

    logic signed [EW-1:0]       w_e;
    logic [NW-1:0]              w_num;
    logic [VW-1:0]              w_v;
    logic [HW-1:0]              w_vh;
    logic [WW-1:0]              w_w;
    logic [HW+13:0]             w_hi;
    logic [PW-1:0]              w_lo_p;
    logic [VW-1:0]              w_quo;
    logic [FW-1:0]              w_q;
    logic                       w_reached;
    logic [rpdbb_pkg::TIME_W-1:0] w_dt;
    logic [24:0]                w_mp;
    logic [MW-1:0]              w_mins;

    assign o_ready = !r_v || i_ready;
    assign w_fire  = i_valid && o_ready;

    // control error, exact
    assign w_e = $signed({{(EW-GW){1'b0}}, i_cfg.target})
               - $signed({{(EW-XW){i_item.temp[XW-1]}}, i_item.temp});
    assign w_reached = (w_e <= 0);

    // floor((1024*e + eF) / 5); 2^16 = 1 mod 5 folds the upper half into the remainder
    assign w_num  = {{(NW-EW-10){w_e[EW-1]}}, w_e, 10'b0} + {r_fe[FW-1], r_fe};
    assign w_v    = {{(VW-NW){w_num[NW-1]}}, w_num} + DIV_BIAS;
    assign w_vh   = w_v[VW-1:16];
    assign w_w    = {1'b0, w_vh} + {{(WW-16){1'b0}}, w_v[15:0]};
    assign w_hi   = (HW+14)'(w_vh) * (HW+14)'(DIV_K16);
    assign w_lo_p = PW'(w_w) * PW'(RECIP5);
    assign w_quo  = VW'(w_hi) + VW'(w_lo_p[PW-1:23]);
    // removing the bias is a drop of bit 32; the filter never leaves 32 bits
    assign w_q    = w_quo[FW-1:0];

    // whole minutes held, saturated: floor(dt/60) = floor(floor(dt/4) / 15)
    assign w_dt   = i_item.now - r_hold;
    assign w_mp   = 25'(w_dt[13:2]) * 25'(RECIP15);
    assign w_mins = (w_dt >= 32'(MIN_SAT_S)) ? {MW{1'b1}} : w_mp[23:16];

    always_comb begin
        n_phase = r_phase;
        n_fe    = r_fe;
        n_hold  = r_hold;
        n_s1.act     = rpdbb_pkg::HACT_KEEP;
        n_s1.buzzer  = 1'b0;
        n_s1.minutes = '0;
        n_s1.reached = 1'b0;
        unique case (i_item.kind)
            rpdbb_pkg::KIND_SAMPLE: begin
                n_s1.reached = w_reached;
                unique case (r_phase)
                    rpdbb_pkg::PH_HEAT: begin
                        n_fe = w_q;
                        if (w_reached) begin
                            n_s1.act = rpdbb_pkg::HACT_OFF;
                            n_phase  = rpdbb_pkg::PH_HOLD;
                            n_hold   = i_item.now;
                        end else begin
                            n_s1.act = rpdbb_pkg::HACT_REG;
                        end
                    end
                    rpdbb_pkg::PH_HOLD: begin
                        n_fe         = w_q;
                        n_s1.minutes = w_mins;
                        n_s1.act     = rpdbb_pkg::HACT_REG;
                        if (i_cfg.rest == '0) begin
                            n_s1.buzzer = 1'b1;
                        end else if (w_mins >= i_cfg.rest) begin
                            n_s1.act = rpdbb_pkg::HACT_OFF;
                            n_phase  = rpdbb_pkg::PH_DONE;
                        end
                    end
                    default: begin
                        // done: no regulation
                        n_s1.act = rpdbb_pkg::HACT_OFF;
                    end
                endcase
            end
            rpdbb_pkg::KIND_CONT: begin
                if (r_phase == rpdbb_pkg::PH_HOLD && i_cfg.rest == '0) begin
                    n_s1.act = rpdbb_pkg::HACT_OFF;
                    n_phase  = rpdbb_pkg::PH_DONE;
                end
            end
            rpdbb_pkg::KIND_START: begin
                n_phase = rpdbb_pkg::PH_HEAT;
            end
            default: ;
        endcase
        n_s1.phase = n_phase;
        n_s1.err   = w_e;
        n_s1.fe    = w_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rpdbb_pkg::PH_HEAT;
            r_fe    <= '0;
            r_hold  <= '0;
            r_v     <= 1'b0;
        end else begin
            if (w_fire) begin
                r_phase <= n_phase;
                r_fe    <= n_fe;
                r_hold  <= n_hold;
                r_v     <= 1'b1;
            end else if (i_ready) begin
                r_v     <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_s1 <= n_s1;
        end
    end

    assign o_valid = r_v;
    assign o_s1    = r_s1;

endmodule

/* hw/rtl/rpdbb_out.sv */
// Drive versus threshold compare, heater state and result register.
module rpdbb_out (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  rpdbb_pkg::t_s1                          i_s1,
    input  logic signed [rpdbb_pkg::THR_W-1:0]      i_thr,
    input  logic                                    i_ready,
    output logic                                    o_ready,
    output logic                                    o_valid,
    output logic [rpdbb_pkg::OUT_DATA_W-1:0]        o_data
);

    localparam int LW = rpdbb_pkg::LHS_W;
    localparam int EW = rpdbb_pkg::ERR_W;
    localparam int FW = rpdbb_pkg::FE_W;
    localparam int TW = rpdbb_pkg::THR_W;
    localparam int OW = rpdbb_pkg::OUT_DATA_W;

    // u * 15625 = (2048 e - 5 eF) * 15625
    localparam logic signed [LW-1:0] DRIVE_E_K = 32000000;
    localparam logic signed [LW-1:0] DRIVE_Q_K = 78125;

    logic signed [LW-1:0]   w_eterm;
    logic signed [LW-1:0]   w_qterm;
    logic signed [LW-1:0]   w_lhs;
    logic signed [LW-1:0]   w_thr;
    logic                   w_on;
    logic                   w_fire;
    logic                   r_heater, n_heater;
    logic                   r_v;
    logic [OW-1:0]          r_data;

    assign o_ready = !r_v || i_ready;
    assign w_fire  = i_valid && o_ready;

    assign w_eterm = $signed({{(LW-EW){i_s1.err[EW-1]}}, i_s1.err}) * DRIVE_E_K;
    assign w_qterm = $signed({{(LW-FW){i_s1.fe[FW-1]}}, i_s1.fe}) * DRIVE_Q_K;
    assign w_lhs   = w_eterm - w_qterm;
    assign w_thr   = {{(LW-TW){i_thr[TW-1]}}, i_thr};
    assign w_on    = (w_lhs > w_thr);

    always_comb begin
        unique case (i_s1.act)
            rpdbb_pkg::HACT_KEEP: n_heater = r_heater;
            rpdbb_pkg::HACT_REG:  n_heater = w_on;
            default:              n_heater = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heater <= 1'b0;
            r_v      <= 1'b0;
        end else begin
            if (w_fire) begin
                r_heater <= n_heater;
                r_v      <= 1'b1;
            end else if (i_ready) begin
                r_v      <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_data <= {3'b000, i_s1.reached, i_s1.minutes, i_s1.buzzer, i_s1.phase, n_heater};
        end
    end

    assign o_valid = r_v;
    assign o_data  = r_data;

endmodule

/* hw/rtl/rest_temperature_pd_bang_bang_unit.sv */
// Rest temperature controller top level: input register, control stage, output stage.
// Each item passes the input, control and output registers in that order; the result is
// valid once the output register holds it.
// Throughput: one item per cycle without backpressure; the filter divide and phase update are combinational.
// Each stage holds its item under backpressure and takes a new one once its successor frees.
// Reset (synchronous, low): phase heating, filter, hold start and heater cleared,
// target 65000 and rest minutes 0; no clearing pass.
module rest_temperature_pd_bang_bang_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: temp_milli[17:0], now_s[49:18], zero pad [55:50]
    input  logic [rpdbb_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [rpdbb_pkg::IN_USER_W-1:0]     i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata: heater_on[0], phase[2:1], buzzer[3], minutes_held[11:4],
    //        temp_reached[12], zero pad [15:13]
    output logic [rpdbb_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rpdbb_pkg::APB_AW-1:0]        paddr,
    input  logic [rpdbb_pkg::APB_DW-1:0]        pwdata,
    output logic [rpdbb_pkg::APB_DW-1:0]        prdata,
    output logic                                pready
);

    localparam int XW = rpdbb_pkg::TEMP_W;
    localparam int TM = rpdbb_pkg::TIME_W;

    rpdbb_pkg::t_cfg                    w_cfg;
    logic signed [rpdbb_pkg::THR_W-1:0] w_thr;
    rpdbb_pkg::t_item                   r_in;
    logic                               r_in_v;
    logic                               w_acc;
    logic                               w_ctrl_ready;
    logic                               w_s1_valid;
    rpdbb_pkg::t_s1                     w_s1;
    logic                               w_out_ready;

    rpdbb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg),
        .o_thr   (w_thr)
    );

    assign o_s_axis_tready = !r_in_v || w_ctrl_ready;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (w_acc) begin
            r_in_v <= 1'b1;
        end else if (w_ctrl_ready) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_in.kind <= i_s_axis_tuser;
            r_in.temp <= i_s_axis_tdata[XW-1:0];
            r_in.now  <= i_s_axis_tdata[XW+TM-1:XW];
        end
    end

    rpdbb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_v),
        .i_item  (r_in),
        .i_cfg   (w_cfg),
        .i_ready (w_out_ready),
        .o_ready (w_ctrl_ready),
        .o_valid (w_s1_valid),
        .o_s1    (w_s1)
    );

    rpdbb_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s1_valid),
        .i_s1    (w_s1),
        .i_thr   (w_thr),
        .i_ready (i_m_axis_tready),
        .o_ready (w_out_ready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (o_m_axis_tdata)
    );

endmodule

/* hw/rtl/rpdbb_checker.sv */
// Port-level assertions for the rest temperature controller, bound to the top level.
`include "assert_macros.svh"

module rpdbb_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic [rpdbb_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);

    logic [1:0] w_phase;
    logic       w_heater;
    logic       w_buzzer;
    logic       w_reached;

    assign w_phase   = o_m_axis_tdata[rpdbb_pkg::OB_PHASE +: 2];
    assign w_heater  = o_m_axis_tdata[rpdbb_pkg::OB_HEATER];
    assign w_buzzer  = o_m_axis_tdata[rpdbb_pkg::OB_BUZZER];
    assign w_reached = o_m_axis_tdata[rpdbb_pkg::OB_REACHED];

    // a done result never reports the heater on
    `ASSERT_NOW(a_done_heater_off, i_clk, i_rst_n, o_m_axis_tvalid && (w_phase == rpdbb_pkg::PH_DONE), !w_heater, "heater on in done phase")

    // the buzzer only sounds while holding
    `ASSERT_NOW(a_buzzer_hold, i_clk, i_rst_n, o_m_axis_tvalid && w_buzzer, w_phase == rpdbb_pkg::PH_HOLD, "buzzer outside holding")

    // a sample at target always leaves the heating phase
    `ASSERT_NOW(a_reached_leaves_heat, i_clk, i_rst_n, o_m_axis_tvalid && w_reached, w_phase != rpdbb_pkg::PH_HEAT, "target reached but still heating")

    // a stalled result stays put
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "result changed under stall")

endmodule

bind rest_temperature_pd_bang_bang_unit rpdbb_checker u_rpdbb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
